[rtl/ric_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ric_pkg
// Shared types and codes for the RGB image convolution block.
// ----------------------------------------------------------------------------
package ric_pkg;

    localparam int KS_W   = 3;
    localparam int DIM_W  = 7;
    localparam int CFG_W  = 7;
    localparam int CIDX_W = 2;
    localparam int PIX_W  = 24;
    localparam int COEF_W = 16;
    localparam int PROD_W = 25;

    localparam logic [1:0] MODE_COEF = 2'd0;
    localparam logic [1:0] MODE_PIX  = 2'd1;
    localparam logic [1:0] MODE_CONV = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_KERNEL = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [5:0]         row;
        logic [5:0]         col;
        logic [5:0]         coef_index;
        logic signed [15:0] coefficient;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } t_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       clipped;
    } t_out;

    typedef struct packed {
        logic live;
        logic inb;
        logic first;
        logic last;
    } t_tap_ctl;

endpackage

[rtl/ric_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ric_store
// Pixel and coefficient memories with registered reads; tap control follows.
// ----------------------------------------------------------------------------
module ric_store #(
    parameter int PIX_DEPTH  = 4096,
    parameter int COEF_DEPTH = 49,
    parameter int PA_W       = 12,
    parameter int CA_W       = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_pix_we,
    input  logic [PA_W-1:0]       i_pix_waddr,
    input  logic [23:0]           i_pix_wdata,
    input  logic                  i_coef_we,
    input  logic [CA_W-1:0]       i_coef_waddr,
    input  logic signed [15:0]    i_coef_wdata,
    input  logic [PA_W-1:0]       i_pix_raddr,
    input  logic [CA_W-1:0]       i_coef_raddr,
    input  ric_pkg::t_tap_ctl     i_ctl,
    output logic [23:0]           o_pix,
    output logic signed [15:0]    o_coef,
    output ric_pkg::t_tap_ctl     o_ctl
);
    import ric_pkg::*;

    logic [PIX_W-1:0]  r_pix_mem  [PIX_DEPTH];
    logic [COEF_W-1:0] r_coef_mem [COEF_DEPTH];
    logic [PIX_W-1:0]  r_pix_q;
    logic [COEF_W-1:0] r_coef_q;
    t_tap_ctl          r_ctl;

    always_ff @(posedge i_clk) begin
        if (i_pix_we) begin
            r_pix_mem[i_pix_waddr] <= i_pix_wdata;
        end
        r_pix_q <= r_pix_mem[i_pix_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_coef_we) begin
            r_coef_mem[i_coef_waddr] <= i_coef_wdata;
        end
        r_coef_q <= r_coef_mem[i_coef_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    assign o_pix  = r_pix_q;
    assign o_coef = $signed(r_coef_q);
    assign o_ctl  = r_ctl;

endmodule

[rtl/ric_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ric_mac
// Three-channel multiply-accumulate with Q8.8 truncation and saturation.
// ----------------------------------------------------------------------------
module ric_mac #(
    parameter int ACC_W = 31
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [23:0]           i_pix,
    input  logic signed [15:0]    i_coef,
    input  ric_pkg::t_tap_ctl     i_ctl,
    output logic                  o_done,
    output ric_pkg::t_out         o_result
);
    import ric_pkg::*;

    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [PROD_W-1:0] n_prod [3];
    logic signed [ACC_W-1:0]  r_acc  [3];
    t_tap_ctl                 r_ctl1;
    logic                     r_fin;
    logic                     r_done;
    t_out                     r_result;
    t_out                     n_result;
    logic [7:0]               n_chan [3];
    logic [2:0]               n_clip;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_prod[i] = i_ctl.inb
                ? PROD_W'(i_coef * $signed({1'b0, i_pix[8*(2-i) +: 8]}))
                : '0;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_acc[i] <= -$signed(ACC_W'(256))) begin
                n_chan[i] = 8'd0;
                n_clip[i] = 1'b1;
            end else if (r_acc[i] >= $signed(ACC_W'(65536))) begin
                n_chan[i] = 8'd255;
                n_clip[i] = 1'b1;
            end else if (r_acc[i] < 0) begin
                n_chan[i] = 8'd0;
                n_clip[i] = 1'b0;
            end else begin
                n_chan[i] = r_acc[i][15:8];
                n_clip[i] = 1'b0;
            end
        end
        n_result.out_red   = n_chan[0];
        n_result.out_green = n_chan[1];
        n_result.out_blue  = n_chan[2];
        n_result.clipped   = |n_clip;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        for (int i = 0; i < 3; i++) begin
            if (r_ctl1.live) begin
                r_acc[i] <= r_ctl1.first ? ACC_W'(r_prod[i]) : r_acc[i] + ACC_W'(r_prod[i]);
            end
        end
        if (r_fin) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_ctl1 <= i_ctl;
            r_fin  <= r_ctl1.live & r_ctl1.last;
            r_done <= r_fin;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

[rtl/ric_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ric_seq
// Tap sequencer: walks the kernel window and issues memory reads.
// ----------------------------------------------------------------------------
module ric_seq #(
    parameter int MAX_WIDTH = 64,
    parameter int PA_W      = 12,
    parameter int CA_W      = 6
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_go,
    input  logic [5:0]             i_row,
    input  logic [5:0]             i_col,
    input  logic [ric_pkg::DIM_W-1:0] i_width,
    input  logic [ric_pkg::DIM_W-1:0] i_height,
    input  logic [ric_pkg::KS_W-1:0]  i_ksize,
    input  logic                   i_done,
    output logic                   o_busy,
    output logic [PA_W-1:0]        o_pix_raddr,
    output logic [CA_W-1:0]        o_coef_raddr,
    output ric_pkg::t_tap_ctl      o_ctl
);
    import ric_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [5:0]       r_row, r_col;
    logic [KS_W-1:0]  r_half;
    logic [KS_W-1:0]  r_k, n_k, r_l, n_l;
    logic [CA_W-1:0]  r_cidx, n_cidx;
    logic             r_first, n_first;
    logic signed [8:0] tap_r, tap_c;
    logic             inb_r, inb_c;
    logic             last_tap;

    always_comb begin
        tap_r = $signed({3'b000, r_row}) - $signed({6'b0, r_half}) + $signed({6'b0, r_k});
        tap_c = $signed({3'b000, r_col}) - $signed({6'b0, r_half}) + $signed({6'b0, r_l});
        inb_r = !tap_r[8] && (tap_r[7:0] < {1'b0, i_height});
        inb_c = !tap_c[8] && (tap_c[7:0] < {1'b0, i_width});
        last_tap = (r_k == i_ksize - 3'd1) && (r_l == i_ksize - 3'd1);
        o_pix_raddr  = PA_W'(PA_W'(tap_r[7:0]) * PA_W'(MAX_WIDTH)) + PA_W'(tap_c[7:0]);
        o_coef_raddr = r_cidx;
        o_ctl.live   = (r_state == S_RUN);
        o_ctl.inb    = (r_state == S_RUN) && inb_r && inb_c;
        o_ctl.first  = r_first;
        o_ctl.last   = last_tap;
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_l     = r_l;
        n_cidx  = r_cidx;
        n_first = r_first;
        case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_state = S_RUN;
                    n_k     = '0;
                    n_l     = '0;
                    n_cidx  = '0;
                    n_first = 1'b1;
                end
            end
            S_RUN: begin
                n_first = 1'b0;
                n_cidx  = r_cidx + CA_W'(1);
                if (last_tap) begin
                    n_state = S_DRAIN;
                end else if (r_l == i_ksize - 3'd1) begin
                    n_l = '0;
                    n_k = r_k + 3'd1;
                end else begin
                    n_l = r_l + 3'd1;
                end
            end
            S_DRAIN: begin
                if (i_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_l     <= n_l;
        r_cidx  <= n_cidx;
        r_first <= n_first;
        if (r_state == S_IDLE && i_go) begin
            r_row  <= i_row;
            r_col  <= i_col;
            r_half <= i_ksize >> 1;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[rtl/rgb_image_convolution_top.sv]
`timescale 1ns / 1ps
// Compute item: the result strobe follows the last tap through the store read, product, accumulate and done registers;
// busy falls in the cycle after the strobe, and only then is a new compute item accepted,
// with taps fed at one tap a cycle through the shared three-channel MAC.
// Coefficient and pixel writes leave busy low.
// Synchronous active-low reset clears control and config; stores are not cleared.
// The result receiver cannot stall: each result is strobed on o_done for one cycle.
// ----------------------------------------------------------------------------
// rgb_image_convolution_top
// RGB 2D convolution with zero padding over stored pixels and Q8.8 kernel.
// ----------------------------------------------------------------------------
module rgb_image_convolution_top #(
    parameter int MAX_KERNEL = 7,
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  ric_pkg::t_in                i_item,
    output logic                        o_done,
    output ric_pkg::t_out               o_result,
    input  logic                        i_cfg_we,
    input  logic [ric_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [ric_pkg::CFG_W-1:0]   i_cfg_data
);
    import ric_pkg::*;

    localparam int COEF_DEPTH = MAX_KERNEL * MAX_KERNEL;
    localparam int PIX_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int PA_W  = $clog2(PIX_DEPTH > 1 ? PIX_DEPTH : 2);
    localparam int CA_W  = $clog2(COEF_DEPTH > 1 ? COEF_DEPTH : 2);
    localparam int ACC_W = PROD_W + $clog2(COEF_DEPTH > 1 ? COEF_DEPTH : 2);
    localparam logic [DIM_W-1:0] W_RST = DIM_W'(MAX_WIDTH < 64 ? MAX_WIDTH : 64);
    localparam logic [DIM_W-1:0] H_RST = DIM_W'(MAX_HEIGHT < 64 ? MAX_HEIGHT : 64);
    localparam logic [KS_W-1:0]  K_RST = KS_W'(MAX_KERNEL < 3 ? MAX_KERNEL : 3);

    logic [DIM_W-1:0] r_width, r_height;
    logic [KS_W-1:0]  r_ksize;
    logic [DIM_W-1:0] n_width, n_height;
    logic [KS_W-1:0]  n_ksize;
    logic             accept;
    logic             pix_we, coef_we;
    logic [PA_W-1:0]  pix_waddr, pix_raddr;
    logic [CA_W-1:0]  coef_raddr;
    logic [23:0]      pix_q;
    logic signed [15:0] coef_q;
    t_tap_ctl         seq_ctl, mem_ctl;
    logic             seq_busy;

    always_comb begin
        n_width = i_cfg_data;
        if (i_cfg_data == '0) begin
            n_width = DIM_W'(1);
        end else if ({4'b0, i_cfg_data} > 11'(MAX_WIDTH)) begin
            n_width = DIM_W'(MAX_WIDTH);
        end
        n_height = i_cfg_data;
        if (i_cfg_data == '0) begin
            n_height = DIM_W'(1);
        end else if ({4'b0, i_cfg_data} > 11'(MAX_HEIGHT)) begin
            n_height = DIM_W'(MAX_HEIGHT);
        end
        n_ksize = i_cfg_data[KS_W-1:0];
        if (i_cfg_data[KS_W-1:0] == '0) begin
            n_ksize = KS_W'(1);
        end else if ({1'b0, i_cfg_data[KS_W-1:0]} > 4'(MAX_KERNEL)) begin
            n_ksize = KS_W'(MAX_KERNEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= W_RST;
            r_height <= H_RST;
            r_ksize  <= K_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_width  <= n_width;
                CFG_HEIGHT: r_height <= n_height;
                CFG_KERNEL: r_ksize  <= n_ksize;
                default: ;
            endcase
        end
    end

    assign accept  = start && !seq_busy;
    assign pix_we  = accept && (i_item.mode == MODE_PIX)
                     && ({5'b0, i_item.row} < 11'(MAX_HEIGHT))
                     && ({5'b0, i_item.col} < 11'(MAX_WIDTH));
    assign coef_we = accept && (i_item.mode == MODE_COEF)
                     && ({2'b0, i_item.coef_index} < 8'(COEF_DEPTH));
    assign pix_waddr = PA_W'(PA_W'(i_item.row) * PA_W'(MAX_WIDTH)) + PA_W'(i_item.col);

    ric_seq #(
        .MAX_WIDTH (MAX_WIDTH),
        .PA_W      (PA_W),
        .CA_W      (CA_W)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (accept && (i_item.mode == MODE_CONV)),
        .i_row        (i_item.row),
        .i_col        (i_item.col),
        .i_width      (r_width),
        .i_height     (r_height),
        .i_ksize      (r_ksize),
        .i_done       (o_done),
        .o_busy       (seq_busy),
        .o_pix_raddr  (pix_raddr),
        .o_coef_raddr (coef_raddr),
        .o_ctl        (seq_ctl)
    );

    ric_store #(
        .PIX_DEPTH  (PIX_DEPTH),
        .COEF_DEPTH (COEF_DEPTH),
        .PA_W       (PA_W),
        .CA_W       (CA_W)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix_we     (pix_we),
        .i_pix_waddr  (pix_waddr),
        .i_pix_wdata  ({i_item.red, i_item.green, i_item.blue}),
        .i_coef_we    (coef_we),
        .i_coef_waddr (CA_W'(i_item.coef_index)),
        .i_coef_wdata (i_item.coefficient),
        .i_pix_raddr  (pix_raddr),
        .i_coef_raddr (coef_raddr),
        .i_ctl        (seq_ctl),
        .o_pix        (pix_q),
        .o_coef       (coef_q),
        .o_ctl        (mem_ctl)
    );

    ric_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pix    (pix_q),
        .i_coef   (coef_q),
        .i_ctl    (mem_ctl),
        .o_done   (o_done),
        .o_result (o_result)
    );

    assign busy = seq_busy;

endmodule
